// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the concentration index RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define HHI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication: when ante holds, cons must hold.
`define HHI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define HHI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/hhi_pkg.sv -----
// Package for the concentration index accumulator: payload structs,
// queue entry type and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hhi_pkg;

  // Field widths fixed by the interface
  localparam int COUNT_BITS  = 20;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_BITS    = FRAC_BITS + 1;
  localparam int SQ_BITS     = 2 * COUNT_BITS;
  localparam int STEP_W      = $clog2(FRAC_BITS + 1);

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // 1.0 in the output fixed-point format
  localparam logic [OUT_BITS-1:0] ONE_FRAC = OUT_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bar_count;
    logic                  missing;
    logic                  row_last;
  } in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] index_fraction;
    logic                index_valid;
  } out_t;

  // Classified bar: count and its square, zero for a missing bar
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [SQ_BITS-1:0]    square;
    logic                  last;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/hhi_front.sv -----
// Front end: accepts input transactions, zeroes the count of missing bars and
// squares the count into a registered queue entry. Uses hhi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hhi_front
  import hhi_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire in_t    in_data,
  output logic        ent_valid,
  input  wire logic   ent_ready,
  output entry_t      ent_data
);

  logic                  stage_valid_r;
  entry_t                stage_r;
  entry_t                stage_nxt;
  logic [COUNT_BITS-1:0] count_eff;

  // Missing bars contribute nothing to either sum
  assign count_eff = in_data.missing ? '0 : in_data.bar_count;

  always_comb begin
    stage_nxt.count  = count_eff;
    stage_nxt.square = SQ_BITS'(count_eff) * SQ_BITS'(count_eff);
    stage_nxt.last   = in_data.row_last;
  end

  assign in_ready  = !stage_valid_r || ent_ready;
  assign ent_valid = stage_valid_r;
  assign ent_data  = stage_r;

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hhi_queue.sv -----
// Short FIFO of classified bars between the front end and the accumulator.
// Uses hhi_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module hhi_queue
  import hhi_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire entry_t push_data,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output entry_t      pop_data
);

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                push;
  logic                pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hhi_accum.sv -----
// Back end accumulator: saturating running total and sum of squares per row,
// handing closed rows to the divider. Uses hhi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hhi_accum
  import hhi_pkg::*;
#(
  parameter int MAX_BARS = 1024,
  parameter int TOT_W    = 30,
  parameter int SQ_W     = 50
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   head_valid,
  output logic        head_ready,
  input  wire entry_t head_data,
  output logic        row_valid,
  input  wire logic   row_ready,
  output logic [TOT_W-1:0] row_total,
  output logic [SQ_W-1:0]  row_sqsum
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOT_W-1:0] TOTAL_CAP =
    TOT_W'(MAX_BARS) * TOT_W'(COUNT_MAX);
  localparam logic [SQ_W-1:0] SQUARE_CAP =
    SQ_W'(MAX_BARS) * SQ_W'(COUNT_MAX) * SQ_W'(COUNT_MAX);

  logic [TOT_W-1:0] total_r;
  logic [SQ_W-1:0]  sq_r;
  logic [TOT_W-1:0] total_nxt;
  logic [SQ_W-1:0]  sq_nxt;
  logic [TOT_W:0]   total_sum;
  logic [SQ_W:0]    sq_sum;
  logic             row_valid_r;
  logic [TOT_W-1:0] row_total_r;
  logic [SQ_W-1:0]  row_sq_r;
  logic             pop;

  // Saturating accumulation
  always_comb begin
    total_sum = {1'b0, total_r} + (TOT_W + 1)'(head_data.count);
    sq_sum    = {1'b0, sq_r} + (SQ_W + 1)'(head_data.square);
    total_nxt = (total_sum > (TOT_W + 1)'(TOTAL_CAP)) ? TOTAL_CAP : total_sum[TOT_W-1:0];
    sq_nxt    = (sq_sum > (SQ_W + 1)'(SQUARE_CAP)) ? SQUARE_CAP : sq_sum[SQ_W-1:0];
  end

  // A closing bar waits until the previous row has gone to the divider
  assign head_ready = !head_data.last || !row_valid_r;
  assign pop        = head_valid && head_ready;

  assign row_valid = row_valid_r;
  assign row_total = row_total_r;
  assign row_sqsum = row_sq_r;

  // Accumulators and row handoff flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      sq_r        <= '0;
      row_valid_r <= 1'b0;
    end else begin
      if (row_valid_r && row_ready) row_valid_r <= 1'b0;
      if (pop) begin
        if (head_data.last) begin
          total_r     <= '0;
          sq_r        <= '0;
          row_valid_r <= 1'b1;
        end else begin
          total_r <= total_nxt;
          sq_r    <= sq_nxt;
        end
      end
    end
  end

  // Closed row totals
  always_ff @(posedge clk) begin
    if (pop && head_data.last) begin
      row_total_r <= total_nxt;
      row_sq_r    <= sq_nxt;
    end
  end

  `HHI_ASSERT(a_total_cap, total_r <= TOTAL_CAP, "running total above saturation cap")
  `HHI_ASSERT(a_square_cap, sq_r <= SQUARE_CAP, "square sum above saturation cap")
  `HHI_ASSERT_NEXT(a_row_hold, row_valid_r && !row_ready, row_valid_r && $stable(row_total_r) && $stable(row_sq_r), "pending row changed before handoff")

endmodule

`default_nettype wire

// ----- hdl/hhi_div.sv -----
// Back end divider: squares the row total, then a restoring divide of the
// square sum by it, one quotient bit per cycle, with rounding and an output
// register. Uses hhi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hhi_div
  import hhi_pkg::*;
#(
  parameter int TOT_W = 30,
  parameter int SQ_W  = 50
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             row_valid,
  output logic                  row_ready,
  input  wire logic [TOT_W-1:0] row_total,
  input  wire logic [SQ_W-1:0]  row_sqsum,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data
);

  localparam int DEN_W = 2 * TOT_W;
  localparam int REM_W = DEN_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_CHECK,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t              state_r;
  logic [TOT_W-1:0]    total_r;
  logic [SQ_W-1:0]     sqsum_r;
  logic [DEN_W-1:0]    den_r;
  logic [REM_W-1:0]    rem_r;
  logic [OUT_BITS-1:0] q_r;
  logic                valid_flag_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;
  out_t                out_data_r;

  logic [DEN_W-1:0]    den_nxt;
  logic [REM_W-1:0]    rem_shift;
  logic                rem_ge;
  logic [OUT_BITS-1:0] q_round;
  logic                out_load;

  // Denominator and one restoring step
  always_comb begin
    den_nxt   = DEN_W'(total_r) * DEN_W'(total_r);
    rem_shift = {rem_r[REM_W-2:0], 1'b0};
    rem_ge    = (rem_shift >= REM_W'(den_r));
    q_round   = q_r + OUT_BITS'(rem_ge);
  end

  // Finished result moves into the output register once it is free
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  assign row_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (row_valid) begin
            total_r <= row_total;
            sqsum_r <= row_sqsum;
            if (row_total == '0) begin
              q_r          <= '0;
              valid_flag_r <= 1'b0;
              state_r      <= S_FINISH;
            end else begin
              valid_flag_r <= 1'b1;
              state_r      <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          den_r   <= den_nxt;
          rem_r   <= REM_W'(sqsum_r);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          // Ratio of at least one is limited to 1.0
          if (rem_r >= REM_W'(den_r)) begin
            q_r     <= ONE_FRAC;
            state_r <= S_FINISH;
          end else begin
            q_r     <= '0;
            step_r  <= '0;
            state_r <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (step_r == STEP_W'(FRAC_BITS)) begin
            // Extra step decides round-half-up
            q_r     <= (q_round > ONE_FRAC) ? ONE_FRAC : q_round;
            state_r <= S_FINISH;
          end else begin
            q_r    <= {q_r[OUT_BITS-2:0], rem_ge};
            rem_r  <= rem_ge ? (rem_shift - REM_W'(den_r)) : rem_shift;
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_data_r.index_fraction <= q_r;
            out_data_r.index_valid    <= valid_flag_r;
            state_r                   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `HHI_ASSERT_IMPL(a_frac_range, out_valid_r, out_data_r.index_fraction <= ONE_FRAC, "index above 1.0")
  `HHI_ASSERT_IMPL(a_invalid_zero, out_valid_r && !out_data_r.index_valid, out_data_r.index_fraction == '0, "invalid result with nonzero index")
  `HHI_ASSERT_IMPL(a_step_range, state_r == S_DIVIDE, step_r <= STEP_W'(FRAC_BITS), "divide step past rounding step")

endmodule

`default_nettype wire

// ----- hdl/concentration_index_accumulator_top.sv -----
// Top level of the concentration index accumulator (Herfindahl-Hirschman).
// Instantiates hhi_front, hhi_queue, hhi_accum and hhi_div; uses hhi_pkg.
//
// Usage:
//   in_*  : one bar per transaction: bar_count, missing (bar skipped) and
//           row_last (closes the row). Valid/ready handshake.
//   out_* : one transaction per closed row: index_fraction = sum of squares /
//           total^2 with FRAC_BITS fraction bits, rounded half up, limited to
//           1.0; index_valid = 0 and index 0 when the row total was zero.
//   Throughput: one bar per cycle while a row accumulates and in_ready is
//   high. Each closed row then occupies the shared divider (one quotient
//   bit per cycle); a row ending while the previous closed row still waits
//   for the divider holds its closing bar until the divider takes that row.
//   Path: the closing bar passes the front stage, queue, row register and
//   the divider states square, check, divide and finish before out_valid;
//   a zero total skips to finish, a ratio of at least 1.0 skips the divide.
//   Reset: synchronous on rst_n low; both accumulators clear, the queue
//   empties and no result is pending.
//   Stall: a held out_ready keeps the result in the output register; the
//   divider, accumulator and queue then fill and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module concentration_index_accumulator_top
  import hhi_pkg::*;
#(
  parameter int MAX_BARS = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int TOT_W = COUNT_BITS + $clog2(MAX_BARS);
  localparam int SQ_W  = SQ_BITS + $clog2(MAX_BARS);

  logic             ent_valid;
  logic             ent_ready;
  entry_t           ent_data;
  logic             head_valid;
  logic             head_ready;
  entry_t           head_data;
  logic             row_valid;
  logic             row_ready;
  logic [TOT_W-1:0] row_total;
  logic [SQ_W-1:0]  row_sqsum;

  hhi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ent_valid (ent_valid),
    .ent_ready (ent_ready),
    .ent_data  (ent_data)
  );

  hhi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (ent_valid),
    .push_ready (ent_ready),
    .push_data  (ent_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_data)
  );

  hhi_accum #(
    .MAX_BARS (MAX_BARS),
    .TOT_W    (TOT_W),
    .SQ_W     (SQ_W)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .head_data  (head_data),
    .row_valid  (row_valid),
    .row_ready  (row_ready),
    .row_total  (row_total),
    .row_sqsum  (row_sqsum)
  );

  hhi_div #(
    .TOT_W (TOT_W),
    .SQ_W  (SQ_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row_total (row_total),
    .row_sqsum (row_sqsum),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for concentration_index_accumulator_top.
// Uses hhi_pkg payload types; predicts each closed row's index and checks every result.
`timescale 1ns / 1ps

module tb_top;
  import hhi_pkg::*;

  localparam int          BAR_LIMIT    = 1024;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASE_BARS   = 150;
  localparam int          LONG_ROW     = 1030;

  localparam logic [COUNT_BITS-1:0] MAX_COUNT    = '1;
  localparam logic [63:0]           TOTAL_CAP    = 64'(BAR_LIMIT) * 64'(MAX_COUNT);
  localparam logic [63:0]           SQUARE_CAP   = TOTAL_CAP * 64'(MAX_COUNT);
  localparam logic [OUT_BITS-1:0]   HALF_FRAC    = ONE_FRAC >> 1;
  localparam logic [OUT_BITS-1:0]   QUARTER_FRAC = ONE_FRAC >> 2;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One directed bar; result is used only when typed is set on a closing bar
  typedef struct packed {
    in_t  bar;
    logic typed;
    out_t result;
  } bar_case_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Predictor state: row accumulators
  logic [29:0] row_total = '0;
  logic [49:0] row_square_sum = '0;
  out_t        expected_indices [$];

  bar_case_t directed_bars [24] = '{
    // zero total right after reset
    '{'{20'd0, 1'b0, 1'b1}, 1'b1, '{17'd0, 1'b0}},
    // missing closing bar on an empty row
    '{'{20'd5, 1'b1, 1'b1}, 1'b1, '{17'd0, 1'b0}},
    // single bar rows: index is 1.0
    '{'{MAX_COUNT, 1'b0, 1'b1}, 1'b1, '{ONE_FRAC, 1'b1}},
    '{'{20'd1, 1'b0, 1'b1}, 1'b1, '{ONE_FRAC, 1'b1}},
    // two equal bars
    '{'{20'd7, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd7, 1'b0, 1'b1}, 1'b1, '{HALF_FRAC, 1'b1}},
    '{'{MAX_COUNT, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{MAX_COUNT, 1'b0, 1'b1}, 1'b1, '{HALF_FRAC, 1'b1}},
    // four equal bars
    '{'{20'd3, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd3, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd3, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd3, 1'b0, 1'b1}, 1'b1, '{QUARTER_FRAC, 1'b1}},
    // missing bar in the middle is skipped
    '{'{20'd100, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{MAX_COUNT, 1'b1, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd100, 1'b0, 1'b1}, 1'b1, '{HALF_FRAC, 1'b1}},
    // missing closing bar still closes a nonempty row
    '{'{20'd50, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd0, 1'b1, 1'b1}, 1'b1, '{ONE_FRAC, 1'b1}},
    // present but zero counts: zero total
    '{'{20'd0, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd0, 1'b0, 1'b1}, 1'b1, '{17'd0, 1'b0}},
    // skewed rows, rounding checked by the predictor
    '{'{20'd1, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{MAX_COUNT, 1'b0, 1'b1}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd1, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd2, 1'b0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
    '{'{20'd3, 1'b0, 1'b1}, 1'b0, '{17'd0, 1'b0}}
  };

  concentration_index_accumulator_top #(
    .MAX_BARS(BAR_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // round(square_sum * 2^FRAC_BITS / total^2), half up, limited to 1.0
  function automatic out_t hhi_index(input logic [29:0] total, input logic [49:0] square_sum);
    logic [127:0] den;
    logic [127:0] twice_quot;
    out_t         idx;
    if (total == '0) begin
      idx.index_fraction = '0;
      idx.index_valid    = 1'b0;
      return idx;
    end
    den        = 128'(total) * 128'(total);
    twice_quot = (128'(square_sum) << (FRAC_BITS + 1)) / den;
    twice_quot = (twice_quot + 128'd1) >> 1;
    if (twice_quot > 128'(ONE_FRAC))
      twice_quot = 128'(ONE_FRAC);
    idx.index_fraction = twice_quot[OUT_BITS-1:0];
    idx.index_valid    = 1'b1;
    return idx;
  endfunction

  // Fold one bar into the row; returns 1 with the index when the bar closes the row
  function automatic bit hhi_accumulate(input in_t bar, output out_t idx);
    logic [63:0] total;
    logic [63:0] square_sum;
    idx = '0;
    if (!bar.missing) begin
      total      = 64'(row_total) + 64'(bar.bar_count);
      square_sum = 64'(row_square_sum) + 64'(bar.bar_count) * 64'(bar.bar_count);
      // saturation on rows longer than BAR_LIMIT
      if (total > TOTAL_CAP)
        total = TOTAL_CAP;
      if (square_sum > SQUARE_CAP)
        square_sum = SQUARE_CAP;
      row_total      = total[29:0];
      row_square_sum = square_sum[49:0];
    end
    if (!bar.row_last)
      return 1'b0;
    idx            = hhi_index(row_total, row_square_sum);
    row_total      = '0;
    row_square_sum = '0;
    return 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return MAX_COUNT;
      2:       return COUNT_BITS'($urandom_range(0, 15));
      default: return COUNT_BITS'($urandom_range(0, int'(MAX_COUNT)));
    endcase
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 48; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default:       begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  // Drive one bar transaction; called right after a rising edge
  task automatic send_bar(input in_t bar, input bit typed, input out_t typed_idx);
    out_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= bar;
    do @(posedge clk); while (!in_ready);
    if (hhi_accumulate(bar, predicted))
      expected_indices.push_back(typed ? typed_idx : predicted);
  endtask

  task automatic send_row(input int unsigned bars, input bit full_scale);
    in_t         bar;
    int unsigned missing_pct;
    missing_pct = ($urandom_range(0, 9) == 0) ? 80 : 12;
    for (int unsigned i = 0; i < bars; i++) begin
      bar.bar_count = full_scale ? MAX_COUNT : pick_count();
      bar.missing   = !full_scale && ($urandom_range(0, 99) < missing_pct);
      bar.row_last  = (i == bars - 1);
      send_bar(bar, 1'b0, '0);
    end
  endtask

  // Hold the input side until every outstanding row result has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_indices.size() != 0);
  endtask

  // Result side backpressure
  always @(posedge clk) begin
    if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct)
      out_ready <= 1'b0;
    else
      out_ready <= 1'b1;
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_indices.size() == 0) begin
        $error("result with no expectation waiting: index_fraction %0d, index_valid %0d",
               out_data.index_fraction, out_data.index_valid);
        fail_count++;
      end else begin
        want = expected_indices.pop_front();
        if (out_data.index_fraction !== want.index_fraction) begin
          $error("index_fraction mismatch: expected %0d, actual %0d",
                 want.index_fraction, out_data.index_fraction);
          fail_count++;
        end
        if (out_data.index_valid !== want.index_valid) begin
          $error("index_valid mismatch: expected %0d, actual %0d",
                 want.index_valid, out_data.index_valid);
          fail_count++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned row_bars;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    set_idling(IDLE_NONE);
    foreach (directed_bars[i])
      send_bar(directed_bars[i].bar, directed_bars[i].typed, directed_bars[i].result);
    wait_drained();

    // Random rows, one phase per idling mode
    for (int m = 0; m < 4; m++) begin
      set_idling(idle_mode_t'(m));
      sent = 0;
      while (sent < PHASE_BARS) begin
        row_bars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
        send_row(row_bars, 1'b0);
        sent += row_bars;
      end
      // one row past BAR_LIMIT at full scale drives both accumulators into saturation
      if (idle_mode_t'(m) == IDLE_NONE)
        send_row(LONG_ROW, 1'b1);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
